>>> design/c3gcf_pkg.sv
// Package for the 3x3 gray convolution filter: widths, limits, register
// indexes and reset values shared by the filter's RTL and its testbench.
// No dependencies.
package c3gcf_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned KROW_W    = 3 * COEF_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = KROW_W;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W    = 2 * PIX_W;

  // product: 9-bit unsigned-as-signed pixel times 16-bit coefficient
  localparam int unsigned PROD_W = PIX_W + 1 + COEF_W;
  localparam int unsigned RSUM_W = PROD_W + 2;
  localparam int unsigned TSUM_W = RSUM_W + 2;

  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
  localparam logic [PIX_W-1:0]   PIX_MAX     = PIX_W'(255);

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);
  localparam logic [KROW_W-1:0]  KTOP_RESET  = '0;
  localparam logic [KROW_W-1:0]  KMID_RESET  = KROW_W'(48'h0000_0100_0000);
  localparam logic [KROW_W-1:0]  KBOT_RESET  = '0;
  localparam logic [COEF_W-1:0]  BIAS_RESET  = '0;

  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_KERNEL_TOP  = 3'd1,
    CFG_KERNEL_MID  = 3'd2,
    CFG_KERNEL_BOT  = 3'd3,
    CFG_BIAS        = 3'd4
  } cfg_reg_e;

endpackage

>>> design/conv3x3_gray_clamp_filter.sv
// Top level of the 3x3 gray convolution filter: line memory, window,
// multiply and sum pipeline, clamp and output register.
// Depends on c3gcf_pkg.
module conv3x3_gray_clamp_filter import c3gcf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata_i,
  // pixel input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] gray_pixel
  input  logic                  s_axis_tuser,  // [0] frame_start
  // filtered output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // [7:0] filtered_pixel,
                                               // [17:8] out_column,
                                               // [29:18] out_row, [31:30] zero
);

  // ---------------------------------------------------------------------------
  // Accepts one gray pixel per clock in raster order; tuser on a word marks
  // the first pixel of a frame and restarts the column and row counters.
  // For every pixel at column >= 2 and row >= 2 one word leaves the block:
  // the clamped 3x3 result for the window centre one row up and one column
  // left, with the centre's coordinates. Border pixels produce no word.
  // Throughput is one pixel per clock, set by the single line memory, which
  // takes one read and one write per cycle. Each result is registered in turn
  // at the memory read, the window, the products and the row sums; then the
  // output register holds its clamped total. The line memory needs no clearing
  // pass, so the block is ready straight out of reset. The whole pipeline
  // advances together: it stalls only when a finished word sits unclaimed in
  // the output register. Write configuration only while the pipeline is empty.
  // ---------------------------------------------------------------------------

  // configuration registers
  logic        [WIDTH_W-1:0]   width_q;
  logic [2:0]  [KROW_W-1:0]    kernel_q;
  logic signed [COEF_W-1:0]    bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RESET;
      kernel_q[0] <= KTOP_RESET;
      kernel_q[1] <= KMID_RESET;
      kernel_q[2] <= KBOT_RESET;
      bias_q      <= BIAS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH: width_q     <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_KERNEL_TOP:  kernel_q[0] <= cfg_wdata_i[KROW_W-1:0];
        CFG_KERNEL_MID:  kernel_q[1] <= cfg_wdata_i[KROW_W-1:0];
        CFG_KERNEL_BOT:  kernel_q[2] <= cfg_wdata_i[KROW_W-1:0];
        CFG_BIAS:        bias_q      <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being emptied
  logic en;
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic accept;
  assign accept = s_axis_tvalid && en;

  // ---------------------------------------------------------------------------
  // Position counters. The effective width is clamped to 3..MAX_WIDTH.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]   col_q, col_d, x;
  logic [ROW_W-1:0]   row_q, row_d, y;
  logic [WIDTH_W-1:0] w_eff;
  logic               emit;

  always_comb begin
    if (width_q < WIDTH_MIN)      w_eff = WIDTH_MIN;
    else if (width_q > WIDTH_MAX) w_eff = WIDTH_MAX;
    else                          w_eff = width_q;

    x = s_axis_tuser ? '0 : col_q;
    y = s_axis_tuser ? '0 : row_q;

    // end the row once the next column would reach the width
    if ({1'b0, x} + WIDTH_W'(1) >= w_eff) begin
      col_d = '0;
      row_d = y + ROW_W'(1);
    end else begin
      col_d = x + COL_W'(1);
      row_d = y;
    end

    emit = (x >= COL_W'(2)) && (y >= ROW_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: one entry per column holds {two rows up, one row up}.
  // Read at acceptance, write back on advance. A pixel accepted in the
  // same cycle as a write to its own column (only possible when a frame
  // restarts at column 0) takes the written value through the bypass.
  // ---------------------------------------------------------------------------
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rdata_q;

  logic              v1_q, emit1_q, fwd1_q;
  logic [ADDR_W-1:0] x1_q;
  logic [PIX_W-1:0]  pix1_q;
  logic [LINE_W-1:0] fwdd1_q;
  logic [COL_W-1:0]  ocol1_q;
  logic [ROW_W-1:0]  orow1_q;

  logic [LINE_W-1:0] line1;
  logic [LINE_W-1:0] wdata1;
  logic              wr1;

  assign line1  = fwd1_q ? fwdd1_q : rdata_q;
  assign wdata1 = {line1[PIX_W-1:0], pix1_q};  // shift the column up one row
  assign wr1    = en && v1_q;

  always_ff @(posedge clk_i) begin
    if (wr1) begin
      line_mem[x1_q] <= wdata1;
    end
    if (accept) begin
      rdata_q <= line_mem[x[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      fwd1_q <= 1'b0;
    end else if (en) begin
      v1_q   <= s_axis_tvalid;
      fwd1_q <= wr1 && (x1_q == x[ADDR_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q    <= x[ADDR_W-1:0];
      pix1_q  <= s_axis_tdata[PIX_W-1:0];
      emit1_q <= emit;
      fwdd1_q <= wdata1;
      ocol1_q <= x - COL_W'(1);
      orow1_q <= y - ROW_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Window: win_q[r][c], column 2 newest. Shift on every pixel.
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][PIX_W-1:0] win_q;
  logic                       v2_q;
  logic [COL_W-1:0]           ocol2_q;
  logic [ROW_W-1:0]           orow2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      v2_q  <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q && emit1_q;
      if (v1_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= line1[LINE_W-1:PIX_W];
        win_q[1][2] <= line1[PIX_W-1:0];
        win_q[2][2] <= pix1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      ocol2_q <= ocol1_q;
      orow2_q <= orow1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Products: coefficient column c weights window column 2-c (mirrored).
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic                     v3_q;
  logic [COL_W-1:0]         ocol3_q;
  logic [ROW_W-1:0]         orow3_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed({1'b0, win_q[r][2-c]}) *
                       $signed(kernel_q[r][COEF_W*c +: COEF_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v2_q) begin
      prod_q  <= prod_d;
      ocol3_q <= ocol2_q;
      orow3_q <= orow2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Row sums.
  // ---------------------------------------------------------------------------
  logic signed [RSUM_W-1:0] rsum_q [3];
  logic                     v4_q;
  logic [COL_W-1:0]         ocol4_q;
  logic [ROW_W-1:0]         orow4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v3_q) begin
      for (int r = 0; r < 3; r++) begin
        rsum_q[r] <= RSUM_W'(prod_q[r][0]) + RSUM_W'(prod_q[r][1]) +
                     RSUM_W'(prod_q[r][2]);
      end
      ocol4_q <= ocol3_q;
      orow4_q <= orow3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Total, truncate toward zero and clamp: any negative total gives 0.
  // ---------------------------------------------------------------------------
  logic signed [TSUM_W-1:0] total;
  logic        [PIX_W-1:0]  clamped;

  always_comb begin
    total = TSUM_W'(rsum_q[0]) + TSUM_W'(rsum_q[1]) + TSUM_W'(rsum_q[2]) +
            TSUM_W'(bias_q);
    if (total[TSUM_W-1]) begin
      clamped = '0;
    end else if (|total[TSUM_W-2:COEF_W]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = total[COEF_W-1:PIX_W];
    end
  end

  // output register
  logic [OUT_DATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v4_q) begin
      m_data_q <= OUT_DATA_W'({orow4_q, ocol4_q, clamped});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  // a same-column write and read in one cycle must arm the bypass
  a_bypass_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && wr1 && (x1_q == x[ADDR_W-1:0])) |=> fwd1_q)
    else $error("line memory bypass not armed on same-column access");

  // a frame start places the pixel at column 0, row 0
  a_frame_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |=> (x1_q == '0) && (col_q == COL_W'(1)))
    else $error("frame start did not restart the column counter");

  // a word in the last stage reaches the output register on advance
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v4_q) |=> m_axis_tvalid)
    else $error("finished result lost before the output register");

  // emitted centres never lie on the first column or row
  a_no_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[COL_W+PIX_W-1:PIX_W] != '0) &&
                      (m_axis_tdata[ROW_W+COL_W+PIX_W-1:COL_W+PIX_W] != '0))
    else $error("border pixel emitted");
`endif

endmodule

>>> verif/conv3x3_gray_clamp_filter_checker.sv
// Checker for the 3x3 gray convolution filter: follows the register port and
// both pixel streams, predicts every filtered word and compares it on arrival.
// Depends on c3gcf_pkg.
module conv3x3_gray_clamp_filter_checker
  import c3gcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  logic [IN_DATA_W-1:0]  pix_data_i,   // [7:0] gray_pixel
  input  logic                  pix_user_i,   // [0] frame_start
  input  logic                  filt_valid_i,
  input  logic                  filt_ready_i,
  input  logic [OUT_DATA_W-1:0] filt_data_i,  // [7:0] pixel, [17:8] column, [29:18] row
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } filt_word_t;

  logic [PIX_W-1:0]   line_hi [MAX_WIDTH];
  logic [PIX_W-1:0]   line_lo [MAX_WIDTH];
  logic [PIX_W-1:0]   win [3][3];
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;
  logic [WIDTH_W-1:0] width_reg;
  logic [KROW_W-1:0]  krow [3];
  logic [COEF_W-1:0]  bias_reg;
  filt_word_t         due_words [$];
  filt_word_t         got, want;

  // Shift one pixel into the line stores and the window; queue a word
  // whenever the window centre is an interior pixel.
  function automatic void filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int         w, x, y;
    logic [PIX_W-1:0] up2, up1;
    longint     acc;
    filt_word_t res;
    w = int'(width_reg);
    if (w < int'(WIDTH_MIN)) w = int'(WIDTH_MIN);
    if (w > int'(WIDTH_MAX)) w = int'(WIDTH_MAX);
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    x = int'(col_cnt);
    y = int'(row_cnt);
    up2 = line_hi[x];
    up1 = line_lo[x];
    line_hi[x] = up1;
    line_lo[x] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = pix;
    if (x >= 2 && y >= 2) begin
      acc = longint'(signed'(bias_reg));
      // column k of the kernel weights the pixel at xc+1-k
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          acc += longint'(win[r][2-k]) * longint'(signed'(krow[r][COEF_W*k +: COEF_W]));
      if (acc < 0)
        res.pix = '0;
      else if ((acc >>> 8) > 255)
        res.pix = PIX_MAX;
      else
        res.pix = PIX_W'(acc >>> 8);
      res.col = COL_W'(x - 1);
      res.row = ROW_W'(y - 1);
      due_words.push_back(res);
    end
    if (x + 1 >= w) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endfunction

  function automatic void compare_field(input string what, input logic [ROW_W-1:0] exp_v,
                                        input logic [ROW_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch on word %0d, expected %0d, actual %0d",
               $time, what, checked_o, exp_v, act_v);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_hi[i] = '0;
        line_lo[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          win[r][k] = '0;
      col_cnt   = '0;
      row_cnt   = '0;
      width_reg = WIDTH_RESET;
      krow[0]   = KTOP_RESET;
      krow[1]   = KMID_RESET;
      krow[2]   = KBOT_RESET;
      bias_reg  = BIAS_RESET;
      due_words.delete();
      errors_o  = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_IMAGE_WIDTH: width_reg = cfg_wdata_i[WIDTH_W-1:0];
          CFG_KERNEL_TOP:  krow[0]   = cfg_wdata_i[KROW_W-1:0];
          CFG_KERNEL_MID:  krow[1]   = cfg_wdata_i[KROW_W-1:0];
          CFG_KERNEL_BOT:  krow[2]   = cfg_wdata_i[KROW_W-1:0];
          CFG_BIAS:        bias_reg  = cfg_wdata_i[COEF_W-1:0];
          default: ;
        endcase
      end
      // a word leaving now was caused by an earlier pixel: pop before push
      if (filt_valid_i && filt_ready_i) begin
        got = filt_word_t'(filt_data_i[$bits(filt_word_t)-1:0]);
        if (due_words.size() == 0) begin
          $display("%0t ns: unexpected filtered word, expected none, actual %h",
                   $time, filt_data_i);
          errors_o++;
        end else begin
          want = due_words.pop_front();
          compare_field("pixel", ROW_W'(want.pix), ROW_W'(got.pix));
          compare_field("column", ROW_W'(want.col), ROW_W'(got.col));
          compare_field("row", want.row, got.row);
          checked_o++;
        end
      end
      if (pix_valid_i && pix_ready_i)
        filter_pixel(pix_data_i[PIX_W-1:0], pix_user_i);
      pending_o = due_words.size();
    end
  end

endmodule

>>> verif/conv3x3_gray_clamp_filter_tb.sv
// Top of the 3x3 gray convolution filter testbench: clock, reset, register
// writes and pixel stimulus, with the verdict. Predicting and comparing is
// left to conv3x3_gray_clamp_filter_checker; types come from c3gcf_pkg.
module conv3x3_gray_clamp_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c3gcf_pkg::*;

  // cycles to let the pipeline empty once no word is due any more
  localparam int HOLD_CYC    = 64;
  // cycles without any word accepted on either stream before giving up
  localparam int STALL_LIMIT = 4000;
  // pixels to send over the whole run
  localparam int ITEM_TARGET = 950;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [7:0] gray_pixel
  logic                  s_axis_tuser  = 1'b0; // [0] frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [7:0] pixel, [17:8] column, [29:18] row

  int          mismatches, pending_words, checked_words;
  int          sent_cnt     = 0;
  int          setting_cnt  = 0;
  int          quiet_cycles = 0;
  int unsigned eff_width    = MAX_WIDTH;   // width the block acts on after reset
  bit          src_calm     = 1'b0;
  bit          sink_calm    = 1'b0;

  cfg_reg_e   kernel_regs [3] = '{CFG_KERNEL_TOP, CFG_KERNEL_MID, CFG_KERNEL_BOT};
  logic [7:0] ramp [9] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127, 8'd64, 8'd2, 8'd200};

  conv3x3_gray_clamp_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  conv3x3_gray_clamp_filter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .pix_user_i   (s_axis_tuser),
    .filt_valid_i (m_axis_tvalid),
    .filt_ready_i (m_axis_tready),
    .filt_data_i  (m_axis_tdata),
    .errors_o     (mismatches),
    .pending_o    (pending_words),
    .checked_o    (checked_words)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink side: stall in about a third of the cycles, unless held calm.
  always @(negedge clk_i) begin
    m_axis_tready <= sink_calm || ($urandom_range(0, 99) >= 32);
  end

  // Watchdog: end the run once neither stream has moved a word for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d filtered words still due",
               $time, STALL_LIMIT, pending_words);
      $display("FAILURE");
      $finish;
    end
  end

  // Write one register, then drop the enable so that it goes low between writes.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one pixel word, with random gaps first, and hold it until taken.
  // Entered and left at a falling edge.
  task automatic send_pixel(input logic [7:0] pix, input logic fs);
    while (!src_calm && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every due word, then let the pipeline run dry so
  // that registers can be rewritten safely.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (HOLD_CYC) @(negedge clk_i);
    setting_cnt++;
  endtask

  // Bias the pixel values towards black and white.
  function automatic logic [7:0] rand_pix();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Wild kernels saturate most sums; gentle ones keep weights within -0.25..+0.375.
  function automatic logic [KROW_W-1:0] kernel_word(input bit wild);
    logic [KROW_W-1:0] kw;
    for (int k = 0; k < 3; k++) begin
      if (!wild)
        kw[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(0, 160)) - COEF_W'(64);
      else if ($urandom_range(0, 3) == 0)
        kw[COEF_W*k +: COEF_W] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      else
        kw[COEF_W*k +: COEF_W] = COEF_W'($urandom);
    end
    return kw;
  endfunction

  function automatic logic [COEF_W-1:0] bias_word(input bit wild);
    return wild ? COEF_W'($urandom) : COEF_W'($urandom_range(0, 8192)) - COEF_W'(4096);
  endfunction

  // One random setting: rewrite some registers, then stream a run of pixels
  // that continues the current frame unless a frame start is drawn.
  task automatic random_setting();
    int unsigned raw_w, new_eff, n;
    bit          fs_due, wild;
    fs_due = ($urandom_range(0, 3) == 0);
    wild   = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       raw_w = $urandom_range(0, 2);   // below the floor, acts as 3
        1:       raw_w = $urandom_range(33, 96);
        default: raw_w = $urandom_range(3, 24);
      endcase
      new_eff = (raw_w < 3) ? 3 : raw_w;
      // A wider row would read line store entries never filled: restart the
      // frame so that two full rows pass before anything is emitted.
      if (new_eff > eff_width) fs_due = 1'b1;
      eff_width = new_eff;
      write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(raw_w));
    end
    foreach (kernel_regs[r])
      if ($urandom_range(0, 1)) write_reg(kernel_regs[r], kernel_word(wild));
    if ($urandom_range(0, 1)) write_reg(CFG_BIAS, CFG_DAT_W'(bias_word(wild)));
    n = $urandom_range(1, 5 * eff_width);
    if (n > 200) n = 200;
    // stop at the pixel budget
    if (n > ITEM_TARGET - sent_cnt) n = ITEM_TARGET - sent_cnt;
    for (int i = 0; i < n; i++)
      send_pixel(rand_pix(), (i == 0 && fs_due) || $urandom_range(0, 99) == 0);
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Identity kernel at the narrowest row; a width of zero must act as 3.
    write_reg(CFG_IMAGE_WIDTH, '0);
    eff_width = 3;
    write_reg(CFG_KERNEL_TOP, KTOP_RESET);
    write_reg(CFG_KERNEL_MID, KMID_RESET);
    write_reg(CFG_KERNEL_BOT, KBOT_RESET);
    write_reg(CFG_BIAS, '0);
    foreach (ramp[i]) send_pixel(ramp[i], i == 0);
    settle();

    // Every weight and the offset at their most positive: clamp at white.
    foreach (kernel_regs[r]) write_reg(kernel_regs[r], {3{16'h7FFF}});
    write_reg(CFG_BIAS, CFG_DAT_W'(16'h7FFF));
    repeat (3) send_pixel(rand_pix(), 1'b0);
    settle();

    // Everything at its most negative: clamp at black.
    foreach (kernel_regs[r]) write_reg(kernel_regs[r], {3{16'h8000}});
    write_reg(CFG_BIAS, CFG_DAT_W'(16'h8000));
    repeat (3) send_pixel(rand_pix(), 1'b0);
    settle();

    // One tap per outer row to expose the column mirroring, a half in the
    // offset to expose the truncation, and a frame restart in mid row.
    write_reg(CFG_KERNEL_TOP, 48'h0000_0000_0100);
    write_reg(CFG_KERNEL_MID, '0);
    write_reg(CFG_KERNEL_BOT, 48'hFF80_0000_0000);
    write_reg(CFG_BIAS, CFG_DAT_W'(16'h0080));
    repeat (4) send_pixel(rand_pix(), 1'b0);
    send_pixel(rand_pix(), 1'b1);
    settle();

    // An out-of-range width acts as the widest row: nothing is due within
    // the first row. Then narrow the row in mid row so that it ends at once,
    // and carry on into the interior of the same frame.
    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(11'h7FF));
    eff_width = MAX_WIDTH;
    for (int i = 0; i < 40; i++) send_pixel(rand_pix(), i == 0);
    settle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(8));
    eff_width = 8;
    for (int i = 0; i < 40; i++) send_pixel(rand_pix(), 1'b0);
    settle();

    // A stretch with no gaps on either side, gentle kernels, new frame.
    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_W'(12));
    eff_width = 12;
    foreach (kernel_regs[r]) write_reg(kernel_regs[r], kernel_word(1'b0));
    write_reg(CFG_BIAS, CFG_DAT_W'(bias_word(1'b0)));
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    for (int i = 0; i < 150; i++) send_pixel(rand_pix(), i == 0);
    settle();
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    while (sent_cnt < ITEM_TARGET) random_setting();

    $display("Streamed %0d pixels under %0d register settings, %0d filtered words checked;",
             sent_cnt, setting_cnt, checked_words);
    $display("rows from 3 to %0d pixels wide, clamping both ways, mid-row width cuts.",
             MAX_WIDTH);
    if (mismatches == 0 && pending_words == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
